// ===== rtl/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg: shared types and codes for the ordered list engine
// Action and status codes, controller states, control struct.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_AFTER = 3'd1;
  localparam logic [2:0] ACT_FIND      = 3'd2;
  localparam logic [2:0] ACT_REMOVE    = 3'd3;
  localparam logic [2:0] ACT_CLEAR     = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_ENTRY  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request word
    logic exec;   // apply request to cell row, build result
  } ctrl_t;

endpackage

// ===== rtl/ole_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl: request sequencer
// Load, execute, then hold result until taken; next word accepted on take.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ole_pkg::ctrl_t  ctrl
);

  ole_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ole_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctrl      = '0;
    unique case (state_r)
      ole_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = ole_pkg::S_EXEC;
        end
      end
      ole_pkg::S_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = ole_pkg::S_OUT;
      end
      ole_pkg::S_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            ctrl.load = 1'b1;
            state_nxt = ole_pkg::S_EXEC;
          end else begin
            state_nxt = ole_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = ole_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ole_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_dp: shifting cell row and result register
// Cells at and past the insert/remove point shift right on insert, left on remove; all compare on find.
// ----------------------------------------------------------------------------
module ole_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ole_pkg::ctrl_t       ctrl,
  input  logic [2:0]           in_action,
  input  logic signed [31:0]   in_item_value,
  input  logic signed [31:0]   in_position,
  output logic [1:0]           out_status,
  output logic [7:0]           out_found_position,
  output logic [8:0]           out_list_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [2:0]         act_r;
  logic [31:0]        val_r;
  logic [31:0]        pos_r;
  logic [31:0]        cell_r [CAPACITY];
  logic [31:0]        cell_nxt [CAPACITY];
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [7:0]         fnd_r, fnd_nxt;
  logic [CAPACITY-1:0] hit;
  logic               full, pos_ok;
  logic [IW-1:0]      pidx;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      act_r <= in_action;
      val_r <= in_item_value;
      pos_r <= in_position;
    end
  end

  assign full   = (cnt_r == CW'(CAPACITY));
  assign pos_ok = !pos_r[31] && (pos_r < 32'(cnt_r));
  assign pidx   = pos_r[IW-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++)
      hit[i] = (cell_r[i] == val_r) && (i < int'(cnt_r));
  end

  always_comb begin
    cell_nxt = cell_r;
    cnt_nxt  = cnt_r;
    st_nxt   = ole_pkg::ST_DONE;
    fnd_nxt  = '0;
    case (act_r)
      ole_pkg::ACT_INS_FRONT: begin
        if (full) st_nxt = ole_pkg::ST_FULL;
        else begin
          for (int i = 1; i < CAPACITY; i++) cell_nxt[i] = cell_r[i-1];
          cell_nxt[0] = val_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ole_pkg::ACT_INS_AFTER: begin
        if (full) st_nxt = ole_pkg::ST_FULL;
        else if (cnt_r == '0) begin
          cell_nxt[0] = val_r;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          for (int i = 2; i < CAPACITY; i++) cell_nxt[i] = cell_r[i-1];
          cell_nxt[1] = val_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ole_pkg::ACT_FIND: begin
        st_nxt = ole_pkg::ST_NOT_FOUND;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (hit[i]) begin
            st_nxt  = ole_pkg::ST_DONE;
            fnd_nxt = 8'(i);
          end
        end
      end
      ole_pkg::ACT_REMOVE: begin
        if (!pos_ok) st_nxt = ole_pkg::ST_NO_ENTRY;
        else begin
          for (int i = 0; i < CAPACITY - 1; i++)
            if (i >= int'(pidx)) cell_nxt[i] = cell_r[i+1];
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ole_pkg::ACT_CLEAR: cnt_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      cell_r <= cell_nxt;
      st_r   <= st_nxt;
      fnd_r  <= fnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         cnt_r <= '0;
    else if (ctrl.exec) cnt_r <= cnt_nxt;
  end

  assign out_status         = st_r;
  assign out_found_position = fnd_r;
  assign out_list_length    = 9'(cnt_r);

endmodule

// ===== rtl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed 32-bit values
// Insert front / after first, find, remove at position, clear.
// ----------------------------------------------------------------------------
// channel | ports                                   | dir
// in      | in_valid/in_ready, in_action, in_item_value, in_position | in
// out     | out_valid/out_ready, out_status, out_found_position,
//         | out_list_length                          | out
//
// Each word is captured into the request register, then, in the execute state,
// the cell row shifts/compares and loads the result register. A held result
// blocks the next request until taken; take and next accept may share a cycle.
// Reset (rst_n, sync) clears controller state and the entry count only.
// Cell row holds CAPACITY entries in flops; entries past the count are ignored.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_found_position,
  output logic [8:0]         out_list_length
);

  ole_pkg::ctrl_t ctrl;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  ole_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_action          (in_action),
    .in_item_value      (in_item_value),
    .in_position        (in_position),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

endmodule
